// ===== hdl/bro_pkg.sv =====
`timescale 1ns / 1ps
package bro_pkg;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 7;
    localparam int ROW_BITS_W = 64;
    localparam int ROW_NUM_W  = 6;
    localparam int CFG_W      = 4;

    localparam logic [PIX_W-1:0] INK_LEVEL = 8'd1;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [SIZE_W-1:0] image_rows;
        logic [SIZE_W-1:0] image_cols;
        logic              last_pixel;
    } bro_in_t;

    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        logic [ROW_NUM_W-1:0]  row_number;
        logic                  last_row;
    } bro_out_t;

    typedef struct packed {
        logic              go;
        logic [SIZE_W-1:0] height;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] filled;
    } bro_glyph_t;

endpackage

// ===== hdl/bro_loader.sv =====
`timescale 1ns / 1ps
module bro_loader #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bro_pkg::bro_in_t              s_data,
    input  logic                          busy,
    output logic                          wr_en,
    output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] wr_addr,
    output logic [MAX_COLS-1:0]           wr_data,
    output bro_pkg::bro_glyph_t           glyph
);
    import bro_pkg::*;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW    = $clog2(MAX_ROWS + 1);
    localparam int CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic                first_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [SIZE_W-1:0]   width_reg;
    logic [RCW-1:0]      row_reg;
    logic [CAW-1:0]      col_reg;
    logic [MAX_COLS-1:0] acc_reg;

    logic                beat;
    logic [SIZE_W-1:0]   clamp_h;
    logic [SIZE_W-1:0]   clamp_w;
    logic [SIZE_W-1:0]   cur_h;
    logic [SIZE_W-1:0]   cur_w;
    logic                in_range;
    logic                row_end;
    logic                ink;
    logic [MAX_COLS-1:0] acc_base;
    logic [MAX_COLS-1:0] new_acc;

    assign s_ready = !busy;
    assign beat    = s_valid && s_ready;

    always_comb begin
        if (s_data.image_rows == '0) begin
            clamp_h = SIZE_W'(1);
        end else if (int'(s_data.image_rows) > MAX_ROWS) begin
            clamp_h = SIZE_W'(MAX_ROWS);
        end else begin
            clamp_h = s_data.image_rows;
        end
        if (s_data.image_cols == '0) begin
            clamp_w = SIZE_W'(1);
        end else if (int'(s_data.image_cols) > MAX_COLS) begin
            clamp_w = SIZE_W'(MAX_COLS);
        end else begin
            clamp_w = s_data.image_cols;
        end
        cur_h    = first_reg ? clamp_h : height_reg;
        cur_w    = first_reg ? clamp_w : width_reg;
        in_range = SIZE_W'(row_reg) < cur_h;
        row_end  = (SIZE_W'(col_reg) + SIZE_W'(1)) == cur_w;
        ink      = s_data.pixel >= INK_LEVEL;
        acc_base = first_reg ? '0 : acc_reg;
        new_acc  = acc_base | ({{(MAX_COLS-1){1'b0}}, ink} << col_reg);
    end

    assign wr_en   = beat && in_range && (row_end || s_data.last_pixel);
    assign wr_addr = row_reg[ROW_AW-1:0];
    assign wr_data = new_acc;

    assign glyph.go     = beat && s_data.last_pixel;
    assign glyph.height = cur_h;
    assign glyph.width  = cur_w;
    assign glyph.filled = in_range ? SIZE_W'(row_reg) + SIZE_W'(1) : SIZE_W'(row_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= 1'b1;
            height_reg <= '0;
            width_reg  <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end else if (beat) begin
            first_reg  <= s_data.last_pixel;
            height_reg <= cur_h;
            width_reg  <= cur_w;
            if (s_data.last_pixel) begin
                row_reg <= '0;
                col_reg <= '0;
            end else if (in_range) begin
                if (row_end) begin
                    row_reg <= row_reg + 1'b1;
                    col_reg <= '0;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && in_range) begin
            if (row_end || s_data.last_pixel) begin
                acc_reg <= '0;
            end else begin
                acc_reg <= new_acc;
            end
        end
    end

endmodule

// ===== hdl/bro_engine.sv =====
`timescale 1ns / 1ps
module bro_engine #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int MAX_WIDTH = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bro_pkg::bro_glyph_t           glyph,
    input  logic                          ink_wr_en,
    input  logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] ink_wr_addr,
    input  logic [MAX_COLS-1:0]           ink_wr_data,
    input  logic [bro_pkg::CFG_W-1:0]     outline_width,
    output logic                          busy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bro_pkg::bro_out_t             m_data
);
    import bro_pkg::*;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UP   = 4'b0010,
        ST_RD   = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    logic [MAX_COLS-1:0] ink_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] out_mem [MAX_ROWS];

    state_t              state_reg;
    logic [SIZE_W-1:0]   h_reg;
    logic [SIZE_W-1:0]   filled_reg;
    logic [MAX_COLS-1:0] mask_reg;
    logic [WW-1:0]       w_reg;
    logic [WW-1:0]       cnt_reg [MAX_COLS];
    logic [MAX_COLS-1:0] prev_reg;
    logic [ROW_AW-1:0]   idx_reg;
    logic [ROW_AW-1:0]   pidx_reg;
    logic                iss_reg;
    logic                pvalid_reg;
    logic                rok_reg;
    logic [MAX_COLS-1:0] ink_q_reg;
    logic [MAX_COLS-1:0] out_q_reg;
    logic                m_valid_reg;
    bro_out_t            m_data_reg;

    logic                rd_en;
    logic [MAX_COLS-1:0] mask_next;
    logic [WW-1:0]       w_next;
    logic [MAX_COLS-1:0] r_cur;
    logic [MAX_COLS-1:0] start_v;
    logic [MAX_COLS-1:0] vmark;
    logic [WW-1:0]       cnt_next [MAX_COLS];
    logic [MAX_COLS-1:0] hs;
    logic [MAX_COLS-1:0] he;
    logic [MAX_COLS-1:0] hmark;
    logic [MAX_COLS-1:0] up_row;
    logic [MAX_COLS-1:0] down_row;
    logic                take;
    logic                last_out;

    assign busy    = (state_reg != ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign rd_en = ((state_reg == ST_UP) && iss_reg) || (state_reg == ST_RD);

    always_comb begin
        logic [WW-1:0] cs;
        cs = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            mask_next[c] = SIZE_W'(c) < glyph.width;
        end
        if (int'(outline_width) > MAX_WIDTH) begin
            w_next = WW'(MAX_WIDTH);
        end else begin
            w_next = WW'(outline_width);
        end
        r_cur   = rok_reg ? (ink_q_reg & mask_reg) : '0;
        start_v = prev_reg & ~r_cur;
        for (int c = 0; c < MAX_COLS; c++) begin
            cs          = start_v[c] ? w_reg : cnt_reg[c];
            vmark[c]    = (cs != '0);
            cnt_next[c] = vmark[c] ? cs - 1'b1 : '0;
        end
        hs    = r_cur & ~(r_cur << 1);
        he    = ~r_cur & (r_cur << 1) & mask_reg;
        hmark = '0;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            if (k < int'(w_reg)) begin
                hmark = hmark | (hs >> (k + 1)) | (he << k);
            end
        end
        up_row   = (hmark | vmark) & mask_reg;
        down_row = (out_q_reg | vmark) & mask_reg;
        take     = !m_valid_reg || m_ready;
        last_out = (SIZE_W'(pidx_reg) + SIZE_W'(1)) == h_reg;
    end

    always_ff @(posedge aclk) begin
        if (ink_wr_en) begin
            ink_mem[ink_wr_addr] <= ink_wr_data;
        end
        if (rd_en) begin
            ink_q_reg <= ink_mem[idx_reg];
            out_q_reg <= out_mem[idx_reg];
        end
        if ((state_reg == ST_UP) && pvalid_reg) begin
            out_mem[pidx_reg] <= up_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iss_reg     <= 1'b0;
            pvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (glyph.go) begin
                        state_reg  <= ST_UP;
                        iss_reg    <= 1'b1;
                        pvalid_reg <= 1'b0;
                    end
                end
                ST_UP: begin
                    pvalid_reg <= iss_reg;
                    if (iss_reg && (idx_reg == '0)) begin
                        iss_reg <= 1'b0;
                    end
                    if (pvalid_reg && (pidx_reg == '0)) begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (take) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= last_out ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (glyph.go) begin
                    h_reg      <= glyph.height;
                    filled_reg <= glyph.filled;
                    mask_reg   <= mask_next;
                    w_reg      <= w_next;
                    idx_reg    <= ROW_AW'(glyph.height - SIZE_W'(1));
                    prev_reg   <= '0;
                    for (int c = 0; c < MAX_COLS; c++) begin
                        cnt_reg[c] <= '0;
                    end
                end
            end
            ST_UP: begin
                if (iss_reg) begin
                    pidx_reg <= idx_reg;
                    rok_reg  <= SIZE_W'(idx_reg) < filled_reg;
                    if (idx_reg != '0) begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                if (pvalid_reg) begin
                    prev_reg <= r_cur;
                    for (int c = 0; c < MAX_COLS; c++) begin
                        cnt_reg[c] <= cnt_next[c];
                    end
                    if (pidx_reg == '0) begin
                        idx_reg  <= '0;
                        prev_reg <= '0;
                        for (int c = 0; c < MAX_COLS; c++) begin
                            cnt_reg[c] <= '0;
                        end
                    end
                end
            end
            ST_RD: begin
                pidx_reg <= idx_reg;
                rok_reg  <= SIZE_W'(idx_reg) < filled_reg;
            end
            ST_OUT: begin
                if (take) begin
                    m_data_reg.row_bits   <= ROW_BITS_W'(down_row);
                    m_data_reg.row_number <= ROW_NUM_W'(pidx_reg);
                    m_data_reg.last_row   <= last_out;
                    prev_reg              <= r_cur;
                    for (int c = 0; c < MAX_COLS; c++) begin
                        cnt_reg[c] <= cnt_next[c];
                    end
                    if (!last_out) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                idx_reg <= '0;
            end
        endcase
    end

endmodule

// ===== hdl/bitmap_run_edge_outline.sv =====
`timescale 1ns / 1ps
// Glyph outline generator.
// The s_ channel takes one grayscale pixel per beat in raster order; the
// size fields are sampled on the first pixel of a glyph and last_pixel ends it.
// A pixel of value 1 or more is ink. Pixels are taken at one per cycle while s_ready is high.
// After the last pixel s_ready drops while the outline is built: an upward
// pass streams the stored rows at one per cycle, then
// a downward pass emits the row words on the m_ channel, top row
// first, with last_row on the final row. Each row of the downward pass goes
// through a read state and an output state, as the row memories have a
// single read port. When the receiver stalls, the downward pass waits
// while the output register holds a row that has not been taken.
// The cfg_ channel writes the outline width; it is always ready and should be
// written only while no glyph is in flight.
// After reset the outline width is 1 and the next pixel starts a new glyph.
module bitmap_run_edge_outline #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int MAX_WIDTH = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bro_pkg::bro_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bro_pkg::bro_out_t         m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bro_pkg::CFG_W-1:0] cfg_data
);
    import bro_pkg::*;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [CFG_W-1:0]    outline_width_reg;
    logic                busy;
    logic                ink_wr_en;
    logic [ROW_AW-1:0]   ink_wr_addr;
    logic [MAX_COLS-1:0] ink_wr_data;
    bro_glyph_t          glyph;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outline_width_reg <= CFG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            outline_width_reg <= cfg_data;
        end
    end

    bro_loader #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) u_loader (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .busy    (busy),
        .wr_en   (ink_wr_en),
        .wr_addr (ink_wr_addr),
        .wr_data (ink_wr_data),
        .glyph   (glyph)
    );

    bro_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_WIDTH(MAX_WIDTH)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .glyph        (glyph),
        .ink_wr_en    (ink_wr_en),
        .ink_wr_addr  (ink_wr_addr),
        .ink_wr_data  (ink_wr_data),
        .outline_width(outline_width_reg),
        .busy         (busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// ===== bench/outline_checker.sv =====
`timescale 1ns / 1ps
module outline_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  bro_pkg::bro_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  bro_pkg::bro_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [3:0]        cfg_data,
    output int                mismatches,
    output int                outstanding
);
    import bro_pkg::*;

    localparam int unsigned MAX_ROWS  = 64;
    localparam int unsigned MAX_COLS  = 64;
    localparam int unsigned MAX_WIDTH = 8;

    logic [63:0]  ink_rows [MAX_ROWS];
    logic [63:0]  outline_rows [MAX_ROWS];
    int unsigned  load_pos;
    int unsigned  glyph_h;
    int unsigned  glyph_w;
    logic [3:0]   outline_width;
    bro_out_t     expected_rows [$];

    int unsigned  area;
    int unsigned  thick;
    logic [63:0]  col_mask;
    logic [63:0]  cur;
    logic [63:0]  prev;
    logic [63:0]  h_start;
    logic [63:0]  h_end;
    logic [63:0]  v_start;
    logic [63:0]  v_end;
    bro_out_t     row_word;
    bro_out_t     want;

    function automatic int unsigned fit_size(input logic [6:0] v, input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (ink_rows[i]) ink_rows[i] = '0;
            load_pos = 0;
            glyph_h = 0;
            glyph_w = 0;
            outline_width = 4'd1;
            mismatches = 0;
            expected_rows.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                outline_width = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (expected_rows.size() == 0) begin
                    report($sformatf("row beat %0d with no row expected", m_data.row_number));
                end else begin
                    want = expected_rows.pop_front();
                    if (m_data.row_bits !== want.row_bits) begin
                        report($sformatf("row %0d bits %h, expected %h", want.row_number,
                                         m_data.row_bits, want.row_bits));
                    end
                    if (m_data.row_number !== want.row_number) begin
                        report($sformatf("row number %0d, expected %0d", m_data.row_number,
                                         want.row_number));
                    end
                    if (m_data.last_row !== want.last_row) begin
                        report($sformatf("row %0d last_row %b, expected %b", want.row_number,
                                         m_data.last_row, want.last_row));
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (load_pos == 0) begin
                    glyph_h = fit_size(s_data.image_rows, MAX_ROWS);
                    glyph_w = fit_size(s_data.image_cols, MAX_COLS);
                    foreach (ink_rows[i]) ink_rows[i] = '0;
                end
                area = glyph_h * glyph_w;
                if (load_pos < area) begin
                    if (s_data.pixel >= INK_LEVEL) begin
                        ink_rows[load_pos / glyph_w][load_pos % glyph_w] = 1'b1;
                    end
                    load_pos++;
                end
                if (s_data.last_pixel) begin
                    thick = (outline_width > MAX_WIDTH) ? MAX_WIDTH : outline_width;
                    col_mask = (glyph_w >= 64) ? '1 : ((64'd1 << glyph_w) - 64'd1);
                    foreach (outline_rows[i]) outline_rows[i] = '0;
                    for (int i = 0; i < glyph_h; i++) begin
                        cur = ink_rows[i] & col_mask;
                        prev = (i > 0) ? (ink_rows[i - 1] & col_mask) : '0;
                        h_start = cur & ~(cur << 1);
                        h_end = ~cur & (cur << 1) & col_mask;
                        v_start = cur & ~prev;
                        v_end = ~cur & prev & col_mask;
                        for (int k = 0; k < thick; k++) begin
                            outline_rows[i] |= h_start >> (k + 1);
                            outline_rows[i] |= h_end << k;
                            if (i >= k + 1) outline_rows[i - k - 1] |= v_start;
                            if (i + k < glyph_h) outline_rows[i + k] |= v_end;
                        end
                    end
                    for (int i = 0; i < glyph_h; i++) begin
                        row_word.row_bits = outline_rows[i] & col_mask;
                        row_word.row_number = i[5:0];
                        row_word.last_row = (i == glyph_h - 1);
                        expected_rows.push_back(row_word);
                    end
                    load_pos = 0;
                end
            end
        end
        outstanding <= expected_rows.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import bro_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 10;
    localparam int LONG_HOLD   = 300;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    bro_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    bro_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;
    int         mismatches;
    int         outstanding;
    int         cycles = 0;
    int         long_hold = 0;
    bit         quiet = 1'b0;
    bit         started = 1'b0;

    always #10 aclk = ~aclk;

    bitmap_run_edge_outline dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    outline_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_glyph(input logic [6:0] rows_f, input logic [6:0] cols_f,
                              input int count, input logic [63:0] pattern,
                              input bit use_pattern, inout int beats);
        bro_in_t beat;
        int      ink_pct;
        int      gap;
        ink_pct = $urandom_range(10, 90);
        for (int n = 0; n < count; n++) begin
            if (use_pattern) begin
                beat.pixel = pattern[n] ? ((n % 2) ? 8'hFF : INK_LEVEL) : 8'h00;
            end else if ($urandom_range(0, 99) < ink_pct) begin
                beat.pixel = 8'($urandom_range(1, 255));
            end else begin
                beat.pixel = 8'h00;
            end
            beat.image_rows = (n == 0) ? rows_f : 7'($urandom_range(0, 127));
            beat.image_cols = (n == 0) ? cols_f : 7'($urandom_range(0, 127));
            beat.last_pixel = (n == count - 1);
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_data <= beat;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
        beats += count;
    endtask

    task automatic set_width(input logic [3:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (started);
        forever begin
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
            end
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int          beats;
        int          phase_beats;
        int          sel;
        int          rows;
        int          cols;
        logic [3:0]  widths [6];
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        started = 1'b1;
        @(posedge aclk);
        beats = 0;

        send_glyph(7'd0, 7'd0, 1, 64'h1, 1'b1, beats);
        send_glyph(7'd3, 7'd3, 9, 64'h010, 1'b1, beats);
        send_glyph(7'd127, 7'd127, 1, 64'h1, 1'b1, beats);
        send_glyph(7'd2, 7'd2, 6, 64'h39, 1'b1, beats);
        send_glyph(7'd2, 7'd4, 8, 64'h3C, 1'b1, beats);

        widths[0] = 4'd0;
        widths[1] = 4'd8;
        widths[2] = 4'd15;
        widths[3] = 4'd2;
        widths[4] = 4'($urandom_range(0, 15));
        widths[5] = 4'($urandom_range(3, 7));
        for (int p = 0; p < 6; p++) begin
            set_width(widths[p]);
            quiet = (p == 3);
            if (p == 1) long_hold = LONG_HOLD;
            phase_beats = 0;
            while (phase_beats < 10) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    send_glyph(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                               $urandom_range(1, 30), '0, 1'b0, phase_beats);
                end else if (sel == 1) begin
                    cols = $urandom_range(33, 64);
                    send_glyph(7'd1, 7'(cols), $urandom_range(1, cols), '0, 1'b0,
                               phase_beats);
                end else if (sel == 2) begin
                    rows = $urandom_range(8, 64);
                    send_glyph(7'(rows), 7'd1, $urandom_range(1, rows), '0, 1'b0,
                               phase_beats);
                end else begin
                    rows = $urandom_range(1, 6);
                    cols = $urandom_range(1, 6);
                    send_glyph(7'(rows), 7'(cols),
                               (sel == 9) ? $urandom_range(1, rows * cols + 4) : rows * cols,
                               '0, 1'b0, phase_beats);
                end
            end
            beats += phase_beats;
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE * 2) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bro_pkg.sv
hdl/bro_loader.sv
hdl/bro_engine.sv
hdl/bitmap_run_edge_outline.sv
bench/outline_checker.sv
bench/testbench.sv
